/* rtl/bsort_pkg.sv */
// Shared types and constants for the adaptive bubble sorter.
// Holds the data width, the default capacity and the transfer structs.
// No dependencies.
`default_nettype none

package bsort_pkg;

  localparam int unsigned DataWidth      = 32;
  localparam int unsigned MaxElementsDef = 64;

  typedef struct packed {
    logic signed [DataWidth-1:0] value;
    logic                        last_in;
  } in_item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] sorted_value;
    logic                        last_out;
    logic                        overflow;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/adaptive_bubble_sorter.sv */
// Adaptive bubble sorter top level: element store, sort sequencer and output.
// Depends on bsort_pkg for the transfer structs and the data width.
//
// Usage: the input channel takes one signed element per transfer, and the
// element that carries last_in closes the set. Up to MAX_ELEMENTS elements
// are kept; later ones are dropped and flag overflow on every result of the
// set. While collecting, in_stall_o stays low and every offered element is
// taken. After the closing element, in_stall_o stays high while the set is
// sorted ascending and sent. Sorting uses one comparator and a store with
// one read and one write port; each pass runs over the active elements, the
// last of which drops off after every pass, and passes stop after one
// without a swap or once only the first two elements were compared. Each
// result is first read from the store and then presented; out_valid_o holds
// with a stable payload while out_stall_i is high. After the last result
// transfer the block clears its count and flag and collects again. Reset
// returns the block to collecting an empty set; the store needs no clearing.
`default_nettype none

module adaptive_bubble_sorter #(
  parameter int unsigned MAX_ELEMENTS = bsort_pkg::MaxElementsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire bsort_pkg::in_item_t  in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output bsort_pkg::out_item_t      out_data_o
);

  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned DW = bsort_pkg::DataWidth;

  typedef enum logic [6:0] {
    S_COLLECT  = 7'b0000001,
    S_SORT_RD0 = 7'b0000010,
    S_SORT_LD  = 7'b0000100,
    S_SORT_CMP = 7'b0001000,
    S_SORT_WB  = 7'b0010000,
    S_OUT_RD   = 7'b0100000,
    S_OUT_SEND = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          dropped_q, dropped_d;
  logic [AW-1:0] hi_q, hi_d;
  logic [AW-1:0] j_q, j_d;
  logic [AW-1:0] k_q, k_d;
  logic          swapped_q, swapped_d;
  logic [DW-1:0] carry_q, carry_d;

  logic [DW-1:0] mem [MAX_ELEMENTS];
  logic [DW-1:0] rdata_q;
  logic          we, re;
  logic [AW-1:0] wa, ra;
  logic [DW-1:0] wd;

  logic          in_xfer, out_xfer, is_last, greater;
  logic [CW-1:0] count_inc;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign out_xfer  = out_valid_o && !out_stall_i;
  assign is_last   = (CW'(k_q) == (count_q - CW'(1)));
  assign greater   = ($signed(carry_q) > $signed(rdata_q));
  assign count_inc = count_q + CW'(1);

  assign in_stall_o  = (state_q != S_COLLECT);
  assign out_valid_o = (state_q == S_OUT_SEND);
  assign out_data_o.sorted_value = rdata_q;
  assign out_data_o.last_out     = is_last;
  assign out_data_o.overflow     = dropped_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    dropped_d = dropped_q;
    hi_d      = hi_q;
    j_d       = j_q;
    k_d       = k_q;
    swapped_d = swapped_q;
    carry_d   = carry_q;
    we        = 1'b0;
    wa        = count_q[AW-1:0];
    wd        = in_data_i.value;
    re        = 1'b0;
    ra        = k_q;
    case (state_q)
      S_COLLECT: begin
        if (in_xfer) begin
          if (count_q < CW'(MAX_ELEMENTS)) begin
            we      = 1'b1;
            count_d = count_inc;
          end else begin
            dropped_d = 1'b1;
          end
          if (in_data_i.last_in) begin
            hi_d = AW'(count_d - CW'(1));
            k_d  = '0;
            if (count_d > CW'(1)) begin
              state_d = S_SORT_RD0;
            end else begin
              state_d = S_OUT_RD;
            end
          end
        end
      end
      S_SORT_RD0: begin
        re        = 1'b1;
        ra        = '0;
        j_d       = AW'(1);
        swapped_d = 1'b0;
        state_d   = S_SORT_LD;
      end
      S_SORT_LD: begin
        carry_d = rdata_q;
        re      = 1'b1;
        ra      = j_q;
        state_d = S_SORT_CMP;
      end
      S_SORT_CMP: begin
        we = 1'b1;
        wa = j_q - AW'(1);
        if (greater) begin
          wd        = rdata_q;
          swapped_d = 1'b1;
        end else begin
          wd      = carry_q;
          carry_d = rdata_q;
        end
        if (j_q == hi_q) begin
          state_d = S_SORT_WB;
        end else begin
          re  = 1'b1;
          ra  = j_q + AW'(1);
          j_d = j_q + AW'(1);
        end
      end
      S_SORT_WB: begin
        we = 1'b1;
        wa = hi_q;
        wd = carry_q;
        if (!swapped_q || (hi_q == AW'(1))) begin
          k_d     = '0;
          state_d = S_OUT_RD;
        end else begin
          hi_d    = hi_q - AW'(1);
          state_d = S_SORT_RD0;
        end
      end
      S_OUT_RD: begin
        re      = 1'b1;
        ra      = k_q;
        state_d = S_OUT_SEND;
      end
      S_OUT_SEND: begin
        if (out_xfer) begin
          if (is_last) begin
            count_d   = '0;
            dropped_d = 1'b0;
            state_d   = S_COLLECT;
          end else begin
            k_d     = k_q + AW'(1);
            state_d = S_OUT_RD;
          end
        end
      end
      default: begin
        state_d = S_COLLECT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_COLLECT;
      count_q   <= '0;
      dropped_q <= 1'b0;
      hi_q      <= '0;
      j_q       <= '0;
      k_q       <= '0;
      swapped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      dropped_q <= dropped_d;
      hi_q      <= hi_d;
      j_q       <= j_d;
      k_q       <= k_d;
      swapped_q <= swapped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata_q <= mem[ra];
    end
  end

  a_count_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ELEMENTS))
    else $error("element count exceeds capacity");

  a_scan_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SORT_CMP) |-> ((j_q != '0) && (j_q <= hi_q)))
    else $error("sort scan index outside the active range");

  a_clear_after_set : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && out_data_o.last_out) |=> ((count_q == '0) && !dropped_q && !in_stall_o))
    else $error("set state not cleared after the final result");

  a_output_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CW'(k_q) < count_q))
    else $error("result index beyond the stored count");

endmodule

`default_nettype wire

/* tb/adaptive_bubble_sorter_checker.sv */
// Transfer monitor and scoreboard for the adaptive bubble sorter.
// Rebuilds each input set, predicts its sorted results and checks the output channel.
// Depends on bsort_pkg for the transfer structs and the data width.
`default_nettype none

module adaptive_bubble_sorter_checker #(
  parameter int Capacity = bsort_pkg::MaxElementsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_stall_i,
  input  wire bsort_pkg::in_item_t  in_data_i,
  input  wire logic                 out_valid_i,
  input  wire logic                 out_stall_i,
  input  wire bsort_pkg::out_item_t out_data_i,
  output int                        fail_count_o,
  output int                        pending_o,
  output int                        results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [bsort_pkg::DataWidth-1:0] set_buf [Capacity];
  int                                     set_len = 0;
  bit                                     set_dropped = 1'b0;
  bsort_pkg::out_item_t                   sorted_q [$];
  bsort_pkg::out_item_t                   expected;
  int                                     mismatches = 0;
  int                                     results = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    results_o    = 0;
  end

  task automatic close_set();
    logic signed [bsort_pkg::DataWidth-1:0] tmp;
    bit                                     swapped;
    bsort_pkg::out_item_t                   res;
    for (int p = 0; p + 1 < set_len; p++) begin
      swapped = 1'b0;
      for (int j = 0; j + 1 < set_len - p; j++) begin
        if (set_buf[j] > set_buf[j+1]) begin
          tmp          = set_buf[j];
          set_buf[j]   = set_buf[j+1];
          set_buf[j+1] = tmp;
          swapped      = 1'b1;
        end
      end
      if (!swapped) break;
    end
    for (int k = 0; k < set_len; k++) begin
      res.sorted_value = set_buf[k];
      res.last_out     = (k + 1 == set_len);
      res.overflow     = set_dropped;
      sorted_q.push_back(res);
    end
    set_len     = 0;
    set_dropped = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_i) begin
      if (set_len < Capacity) begin
        set_buf[set_len] = in_data_i.value;
        set_len++;
      end else begin
        set_dropped = 1'b1;
      end
      if (in_data_i.last_in) close_set();
    end
    if (rst_ni && out_valid_i && !out_stall_i) begin
      results++;
      if (sorted_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result value %0d last %0b overflow %0b", $realtime,
                   out_data_i.sorted_value, out_data_i.last_out, out_data_i.overflow);
        mismatches++;
      end else begin
        expected = sorted_q.pop_front();
        if (out_data_i.sorted_value !== expected.sorted_value ||
            out_data_i.last_out !== expected.last_out ||
            out_data_i.overflow !== expected.overflow) begin
          if (mismatches < 10)
            $display("%0t: mismatch, expected value %0d last %0b overflow %0b, got %0d %0b %0b",
                     $realtime, expected.sorted_value, expected.last_out, expected.overflow,
                     out_data_i.sorted_value, out_data_i.last_out, out_data_i.overflow);
          mismatches++;
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= sorted_q.size();
    results_o    <= results;
  end

endmodule

`default_nettype wire

/* tb/adaptive_bubble_sorter_test.sv */
// Top of the adaptive bubble sorter testbench: clock, reset, stimulus and verdict.
// Instantiates the sorter and adaptive_bubble_sorter_checker; depends on bsort_pkg.
`default_nettype none

module adaptive_bubble_sorter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Capacity    = bsort_pkg::MaxElementsDef;
  localparam int CycleLimit  = 400000;
  localparam int HoldCycles  = 400;
  localparam int DrainCycles = 50;
  localparam int RandomItems = 300;

  logic                 clk_i;
  logic                 rst_ni    = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  bsort_pkg::in_item_t  in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  bsort_pkg::out_item_t out_data;

  int fail_count;
  int pending;
  int results;
  int cycles      = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  bit hold_req    = 1'b0;
  int items_sent  = 0;
  int sets_sent   = 0;
  int full_sets   = 0;

  adaptive_bubble_sorter #(
    .MAX_ELEMENTS(Capacity)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  adaptive_bubble_sorter_checker #(
    .Capacity(Capacity)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // The hold-off keeps the output stalled long enough for the input side to back up.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  task automatic offer(input logic signed [bsort_pkg::DataWidth-1:0] v, input logic l);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{value: v, last_in: l};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    items_sent++;
  endtask

  function automatic logic signed [bsort_pkg::DataWidth-1:0] rand_elem();
    case ($urandom_range(3))
      0: return $signed($urandom_range(15)) - 8;
      1: begin
        case ($urandom_range(5))
          0: return {1'b1, {(bsort_pkg::DataWidth-1){1'b0}}};
          1: return {1'b0, {(bsort_pkg::DataWidth-1){1'b1}}};
          2: return '0;
          3: return '1;
          4: return 1;
          default: return {1'b1, {(bsort_pkg::DataWidth-2){1'b0}}, 1'b1};
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic send_list(input logic signed [bsort_pkg::DataWidth-1:0] vals [$]);
    for (int i = 0; i < vals.size(); i++) offer(vals[i], i == vals.size() - 1);
    sets_sent++;
  endtask

  task automatic send_random_set(input int n);
    for (int i = 0; i < n; i++) offer(rand_elem(), i == n - 1);
    sets_sent++;
    if (n > Capacity) full_sets++;
  endtask

  function automatic int pick_set_size();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $urandom_range(1, 8);
    if (r < 96) return $urandom_range(9, 20);
    if (r < 98) return $urandom_range(Capacity - 2, Capacity);
    return $urandom_range(Capacity + 1, Capacity + 4);
  endfunction

  task automatic run_phase(input int tx_pct, input int rx_pct, input int item_goal);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    while (items_sent < item_goal) send_random_set(pick_set_size());
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_idle_pct = 16;
    rx_idle_pct = 51;
    send_list('{32'sh8000_0000});
    send_list('{32'sh7fff_ffff, 32'sh8000_0000, 32'sh0, -32'sd1, 32'sd1});
    send_list('{-32'sd5, -32'sd5, 32'sd3, -32'sd5});
    send_list('{32'sd1, 32'sd2, 32'sd3, 32'sd4});
    send_list('{32'sd40, 32'sd30, 32'sd20, 32'sd10, 32'sd0, -32'sd10});
    send_list('{32'sh5555_5555, 32'shaaaa_aaaa});
    send_random_set(Capacity);
    send_random_set(Capacity + 1);

    hold_req = 1'b1;
    send_random_set(10);
    send_random_set(6);
    run_phase(16, 51, items_sent + RandomItems / 3);
    run_phase(51, 16, items_sent + RandomItems / 3);
    run_phase(0, 0, items_sent + RandomItems / 3);
    in_valid <= 1'b0;
    @(posedge clk_i);

    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d input transfers in %0d sets, %0d of them over capacity.",
             items_sent, sets_sent, full_sets);
    $display("Checked %0d sorted results with %0d mismatches.", results, fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* adaptive_bubble_sorter.f */
rtl/bsort_pkg.sv
rtl/adaptive_bubble_sorter.sv
tb/adaptive_bubble_sorter_checker.sv
tb/adaptive_bubble_sorter_test.sv
